>>> design/binary_trie_max_xor_multiset_macros.svh
// Assertion helpers used by the top-level block file.
`ifndef BINARY_TRIE_MAX_XOR_MULTISET_MACROS_SVH
`define BINARY_TRIE_MAX_XOR_MULTISET_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define BTMX_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BTMX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/btmx_pkg.sv
package btmx_pkg;

  localparam int VALUE_BITS = 32;
  localparam int NODE_COUNT = 4096;
  localparam int COUNT_BITS = 16;
  localparam int IDX_BITS   = $clog2(NODE_COUNT);
  localparam int FREE_BITS  = IDX_BITS + 1;
  localparam int LVL_BITS   = $clog2(VALUE_BITS);
  localparam int LIVE_BITS  = 16;

  localparam logic [LIVE_BITS-1:0] TOTAL_MAX =
    (COUNT_BITS < LIVE_BITS) ? LIVE_BITS'((64'd1 << COUNT_BITS) - 64'd1)
                             : {LIVE_BITS{1'b1}};

  localparam logic [FREE_BITS-1:0] FREE_LIMIT = FREE_BITS'(NODE_COUNT - VALUE_BITS);

  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_REMOVE = 2'd1,
    FN_QUERY  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_ROOM = 2'd1,
    ST_ABSENT  = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SEL,
    S_EVAL,
    S_NEW,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [IDX_BITS-1:0]   c0;
    logic [IDX_BITS-1:0]   c1;
    logic [COUNT_BITS-1:0] cnt;
  } node_t;

  typedef struct packed {
    logic                we;
    logic [IDX_BITS-1:0] waddr;
    node_t               wdata;
    logic                re;
    logic [IDX_BITS-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] max_xor;
    status_e               status;
  } res_t;

endpackage

>>> design/btmx_if.sv
interface btmx_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface btmx_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] max_xor;
  logic [1:0]  status;

  modport source (output valid, output max_xor, output status, input ready);
  modport sink   (input valid, input max_xor, input status, output ready);
endinterface

>>> design/btmx_mem.sv
module btmx_mem (
  input  logic                 clk_i,
  input  btmx_pkg::mem_req_t   req_i,
  output btmx_pkg::node_t      rdata_o
);

  btmx_pkg::node_t mem [btmx_pkg::NODE_COUNT];
  btmx_pkg::node_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/btmx_ctrl.sv
module btmx_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [1:0]                          func_i,
  input  logic [btmx_pkg::VALUE_BITS-1:0]     value_i,
  output logic                                ready_o,
  input  logic                                res_free_i,
  output logic                                res_valid_o,
  output btmx_pkg::res_t                      res_o,
  output btmx_pkg::mem_req_t                  mem_req_o,
  input  btmx_pkg::node_t                     mem_rd_i
);

  btmx_pkg::state_e state_q, state_d;

  logic [1:0]                         op_q;
  logic [btmx_pkg::VALUE_BITS-1:0]    value_q;
  logic [btmx_pkg::LVL_BITS-1:0]      lvl_q, lvl_d;
  logic [btmx_pkg::IDX_BITS-1:0]      cur_idx_q, cur_idx_d;
  btmx_pkg::node_t                    cur_word_q, cur_word_d;
  logic [btmx_pkg::VALUE_BITS-1:0]    acc_q, acc_d;
  logic                               phase_q, phase_d;
  logic                               opp_q, opp_d;
  btmx_pkg::status_e                  status_q, status_d;
  logic [btmx_pkg::FREE_BITS-1:0]     next_free_q, next_free_d;
  logic [btmx_pkg::LIVE_BITS-1:0]     live_q, live_d;
  logic [btmx_pkg::IDX_BITS-1:0]      root_c0_q, root_c0_d;
  logic [btmx_pkg::IDX_BITS-1:0]      root_c1_q, root_c1_d;

  logic                               bit_b;
  logic                               last_lvl;
  logic                               ins_full;
  logic [btmx_pkg::IDX_BITS-1:0]      same_idx;
  logic [btmx_pkg::IDX_BITS-1:0]      opp_idx;
  logic [btmx_pkg::IDX_BITS-1:0]      new_idx;
  btmx_pkg::node_t                    root_word;
  btmx_pkg::node_t                    fresh_word;
  btmx_pkg::node_t                    link_word;
  btmx_pkg::node_t                    upd_word;

  assign bit_b    = value_q[lvl_q];
  assign last_lvl = (lvl_q == '0);
  assign same_idx = bit_b ? cur_word_q.c1 : cur_word_q.c0;
  assign opp_idx  = bit_b ? cur_word_q.c0 : cur_word_q.c1;
  assign new_idx  = next_free_q[btmx_pkg::IDX_BITS-1:0];
  assign ins_full = (next_free_q > btmx_pkg::FREE_LIMIT) || (live_q >= btmx_pkg::TOTAL_MAX);

  assign root_word  = '{c0: root_c0_q, c1: root_c1_q, cnt: '0};
  assign fresh_word = '{c0: '0, c1: '0, cnt: btmx_pkg::COUNT_BITS'(1)};

  always_comb begin
    link_word = cur_word_q;
    if (bit_b) begin
      link_word.c1 = new_idx;
    end else begin
      link_word.c0 = new_idx;
    end
  end

  always_comb begin
    upd_word = mem_rd_i;
    if (op_q == btmx_pkg::FN_INSERT) begin
      upd_word.cnt = mem_rd_i.cnt + 1'b1;
    end else begin
      upd_word.cnt = mem_rd_i.cnt - 1'b1;
    end
  end

  assign ready_o     = (state_q == btmx_pkg::S_IDLE);
  assign res_valid_o = (state_q == btmx_pkg::S_FIN) && res_free_i;
  assign res_o       = '{max_xor: acc_q, status: status_q};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      btmx_pkg::S_IDLE: begin
        if (start_i) state_d = btmx_pkg::S_START;
      end
      btmx_pkg::S_START: begin
        unique case (op_q)
          btmx_pkg::FN_INSERT: state_d = ins_full ? btmx_pkg::S_FIN : btmx_pkg::S_SEL;
          btmx_pkg::FN_REMOVE: state_d = btmx_pkg::S_SEL;
          btmx_pkg::FN_QUERY:  state_d = (live_q == '0) ? btmx_pkg::S_FIN : btmx_pkg::S_SEL;
          default:             state_d = btmx_pkg::S_FIN;
        endcase
      end
      btmx_pkg::S_SEL: begin
        unique case (op_q)
          btmx_pkg::FN_INSERT: state_d = (same_idx == '0) ? btmx_pkg::S_NEW : btmx_pkg::S_EVAL;
          btmx_pkg::FN_REMOVE: state_d = (same_idx == '0) ? btmx_pkg::S_FIN : btmx_pkg::S_EVAL;
          default: begin
            state_d = (opp_idx == '0 && same_idx == '0) ? btmx_pkg::S_FIN : btmx_pkg::S_EVAL;
          end
        endcase
      end
      btmx_pkg::S_EVAL: begin
        unique case (op_q)
          btmx_pkg::FN_INSERT: state_d = last_lvl ? btmx_pkg::S_FIN : btmx_pkg::S_SEL;
          btmx_pkg::FN_REMOVE: begin
            if (!phase_q && mem_rd_i.cnt == '0) begin
              state_d = btmx_pkg::S_FIN;
            end else if (phase_q && last_lvl) begin
              state_d = btmx_pkg::S_FIN;
            end else begin
              state_d = btmx_pkg::S_SEL;
            end
          end
          default: begin
            if (opp_q && mem_rd_i.cnt == '0) begin
              state_d = (same_idx == '0) ? btmx_pkg::S_FIN : btmx_pkg::S_EVAL;
            end else begin
              state_d = last_lvl ? btmx_pkg::S_FIN : btmx_pkg::S_SEL;
            end
          end
        endcase
      end
      btmx_pkg::S_NEW: state_d = last_lvl ? btmx_pkg::S_FIN : btmx_pkg::S_SEL;
      btmx_pkg::S_FIN: begin
        if (res_free_i) state_d = btmx_pkg::S_IDLE;
      end
      default: state_d = btmx_pkg::S_IDLE;
    endcase
  end

  // datapath and memory port
  always_comb begin
    lvl_d       = lvl_q;
    cur_idx_d   = cur_idx_q;
    cur_word_d  = cur_word_q;
    acc_d       = acc_q;
    phase_d     = phase_q;
    opp_d       = opp_q;
    status_d    = status_q;
    next_free_d = next_free_q;
    live_d      = live_q;
    root_c0_d   = root_c0_q;
    root_c1_d   = root_c1_q;
    mem_req_o   = '0;

    unique case (state_q)
      btmx_pkg::S_START: begin
        lvl_d      = btmx_pkg::LVL_BITS'(btmx_pkg::VALUE_BITS - 1);
        cur_idx_d  = '0;
        cur_word_d = root_word;
        acc_d      = '0;
        phase_d    = 1'b0;
        status_d   = btmx_pkg::ST_OK;
        if (op_q == btmx_pkg::FN_INSERT && ins_full) begin
          status_d = btmx_pkg::ST_NO_ROOM;
        end else if (op_q == btmx_pkg::FN_QUERY && live_q == '0) begin
          status_d = btmx_pkg::ST_EMPTY;
        end
      end
      btmx_pkg::S_SEL: begin
        unique case (op_q)
          btmx_pkg::FN_INSERT: begin
            if (same_idx == '0) begin
              if (cur_idx_q == '0) begin
                if (bit_b) root_c1_d = new_idx;
                else       root_c0_d = new_idx;
              end else begin
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = cur_idx_q;
                mem_req_o.wdata = link_word;
              end
              cur_idx_d   = new_idx;
              cur_word_d  = fresh_word;
              next_free_d = next_free_q + 1'b1;
            end else begin
              mem_req_o.re    = 1'b1;
              mem_req_o.raddr = same_idx;
              cur_idx_d       = same_idx;
            end
          end
          btmx_pkg::FN_REMOVE: begin
            if (same_idx == '0) begin
              status_d = btmx_pkg::ST_ABSENT;
            end else begin
              mem_req_o.re    = 1'b1;
              mem_req_o.raddr = same_idx;
              cur_idx_d       = same_idx;
            end
          end
          default: begin
            mem_req_o.re = (opp_idx != '0) || (same_idx != '0);
            if (opp_idx != '0) begin
              mem_req_o.raddr = opp_idx;
              opp_d           = 1'b1;
            end else begin
              mem_req_o.raddr = same_idx;
              opp_d           = 1'b0;
            end
          end
        endcase
      end
      btmx_pkg::S_EVAL: begin
        unique case (op_q)
          btmx_pkg::FN_INSERT: begin
            mem_req_o.we    = 1'b1;
            mem_req_o.waddr = cur_idx_q;
            mem_req_o.wdata = upd_word;
            cur_word_d      = upd_word;
            if (last_lvl) live_d = live_q + 1'b1;
            else          lvl_d  = lvl_q - 1'b1;
          end
          btmx_pkg::FN_REMOVE: begin
            if (!phase_q) begin
              if (mem_rd_i.cnt == '0) begin
                status_d = btmx_pkg::ST_ABSENT;
              end else if (last_lvl) begin
                phase_d    = 1'b1;
                lvl_d      = btmx_pkg::LVL_BITS'(btmx_pkg::VALUE_BITS - 1);
                cur_idx_d  = '0;
                cur_word_d = root_word;
              end else begin
                cur_word_d = mem_rd_i;
                lvl_d      = lvl_q - 1'b1;
              end
            end else begin
              mem_req_o.we    = 1'b1;
              mem_req_o.waddr = cur_idx_q;
              mem_req_o.wdata = upd_word;
              cur_word_d      = upd_word;
              if (last_lvl) begin
                if (live_q != '0) live_d = live_q - 1'b1;
              end else begin
                lvl_d = lvl_q - 1'b1;
              end
            end
          end
          default: begin
            if (opp_q && mem_rd_i.cnt == '0) begin
              mem_req_o.re    = (same_idx != '0);
              mem_req_o.raddr = same_idx;
              opp_d           = 1'b0;
            end else begin
              if (opp_q) acc_d[lvl_q] = 1'b1;
              cur_word_d = mem_rd_i;
              if (!last_lvl) lvl_d = lvl_q - 1'b1;
            end
          end
        endcase
      end
      btmx_pkg::S_NEW: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = cur_idx_q;
        mem_req_o.wdata = cur_word_q;
        if (last_lvl) live_d = live_q + 1'b1;
        else          lvl_d  = lvl_q - 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= btmx_pkg::S_IDLE;
      next_free_q <= btmx_pkg::FREE_BITS'(1);
      live_q      <= '0;
      root_c0_q   <= '0;
      root_c1_q   <= '0;
      phase_q     <= 1'b0;
      opp_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      next_free_q <= next_free_d;
      live_q      <= live_d;
      root_c0_q   <= root_c0_d;
      root_c1_q   <= root_c1_d;
      phase_q     <= phase_d;
      opp_q       <= opp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && ready_o) begin
      op_q    <= func_i;
      value_q <= value_i;
    end
    lvl_q      <= lvl_d;
    cur_idx_q  <= cur_idx_d;
    cur_word_q <= cur_word_d;
    acc_q      <= acc_d;
    status_q   <= status_d;
  end

endmodule

>>> design/binary_trie_max_xor_multiset.sv
// Maximum-XOR multiset over 32-bit values, kept in a bitwise trie.
// in_i  : func (0 insert, 1 remove one copy, 2 max-xor query) and value.
// out_o : one item per input item, max_xor and status
//         (0 ok, 1 no room, 2 value not present, 3 set empty).
// Both channels use valid/ready; an item moves when both are high.
// One item is in work at a time; ready drops after an accept and rises
// again once the result sits in the output register.
// Walks the 32 trie levels through the single node memory port with registered
// read data. Per level, insert uses a select state then an update or allocate
// state; query a select and an evaluate state, plus a second evaluate when the
// opposite branch is empty; remove a presence check pass then count update pass.
// Setup and hand-off frame each walk; rejected inserts and empty queries skip it.
// Reset: set empty, root links cleared, node pool handed out from node 1.
// The pool needs no clearing pass; nodes are written when allocated.
// If the receiver stalls, the result waits in the output register; the
// block still takes one new item and holds its result until room frees.
`include "binary_trie_max_xor_multiset_macros.svh"

module binary_trie_max_xor_multiset (
  input  logic       clk_i,
  input  logic       rst_ni,
  btmx_in_if.sink    in_i,
  btmx_out_if.source out_o
);

  logic                 start;
  logic                 ctrl_ready;
  logic                 res_free;
  logic                 res_valid;
  btmx_pkg::res_t       res;
  btmx_pkg::mem_req_t   mem_req;
  btmx_pkg::node_t      mem_rd;

  logic                 out_valid_q;
  btmx_pkg::res_t       out_res_q;

  assign in_i.ready = ctrl_ready;
  assign start      = in_i.valid && ctrl_ready;
  assign res_free   = !out_valid_q || out_o.ready;

  btmx_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .func_i      (in_i.func),
    .value_i     (in_i.value),
    .ready_o     (ctrl_ready),
    .res_free_i  (res_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .mem_rd_i    (mem_rd)
  );

  btmx_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.max_xor = out_res_q.max_xor;
  assign out_o.status  = out_res_q.status;

  `BTMX_ASSERT_NOW(a_res_room, res_valid, !out_valid_q || out_o.ready, "result with output full")
  `BTMX_ASSERT_NEXT(a_busy_after_accept, start, !in_i.ready, "ready after accept")
  `BTMX_ASSERT_NEXT(a_res_loaded, res_valid, out_valid_q, "result not loaded")
  `BTMX_ASSERT_NOW(a_res_not_idle, res_valid, !in_i.ready, "result while idle")

endmodule
